@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define LCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define LCC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/lcc_pkg.sv @@
// Types and fixed-point constants of the luma replacing color converter.
package lcc_pkg;

    localparam int unsigned SUM_W = 44;

    localparam logic signed [15:0] CB_R = -16'sd9714;
    localparam logic signed [15:0] CB_G = -16'sd19070;
    localparam logic signed [15:0] CB_B = 16'sd28785;
    localparam logic signed [15:0] CR_R = 16'sd28785;
    localparam logic signed [15:0] CR_G = -16'sd24103;
    localparam logic signed [15:0] CR_B = -16'sd4681;
    localparam logic signed [25:0] CHROMA_MID_Q16 = 26'sd8388608;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic signed [18:0] K_Y    = 19'sd76309;
    localparam logic signed [18:0] K_R_CR = 19'sd104597;
    localparam logic signed [18:0] K_G_CB = -19'sd25674;
    localparam logic signed [18:0] K_G_CR = -19'sd53280;
    localparam logic signed [18:0] K_B_CB = 19'sd132203;

    localparam logic signed [SUM_W-1:0] OFF_R_Q32 = -(44'sd14609351 * 44'sd65536);
    localparam logic signed [SUM_W-1:0] OFF_G_Q32 = 44'sd8885109 * 44'sd65536;
    localparam logic signed [SUM_W-1:0] OFF_B_Q32 = -(44'sd18142724 * 44'sd65536);

    typedef struct packed {
        logic [23:0] cb;
        logic [23:0] cr;
        logic [23:0] y;
    } lcc_ycc_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] y_k;
        logic signed [SUM_W-1:0] cr_r;
        logic signed [SUM_W-1:0] cb_g;
        logic signed [SUM_W-1:0] cr_g;
        logic signed [SUM_W-1:0] cb_b;
    } lcc_prod_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] g;
        logic signed [SUM_W-1:0] b;
    } lcc_sum_t;

endpackage

@@ hw/rtl/lcc_chroma.sv @@
// First stage: Cb and Cr from RGB, clamped and scaled replacement luma.
module lcc_chroma import lcc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic signed [17:0] luma,
    output logic               out_valid,
    input  logic               out_ready,
    output lcc_ycc_t           out_data
);

    logic               valid_reg;
    lcc_ycc_t           data_reg;
    lcc_ycc_t           data_next;
    logic signed [8:0]  r_s;
    logic signed [8:0]  g_s;
    logic signed [8:0]  b_s;
    logic signed [25:0] cb_full;
    logic signed [25:0] cr_full;
    logic [16:0]        luma_clamped;
    logic [24:0]        y_full;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        r_s = $signed({1'b0, red});
        g_s = $signed({1'b0, green});
        b_s = $signed({1'b0, blue});
        cb_full = CB_R * r_s + CB_G * g_s + CB_B * b_s + CHROMA_MID_Q16;
        cr_full = CR_R * r_s + CR_G * g_s + CR_B * b_s + CHROMA_MID_Q16;
        if (luma[17]) begin
            luma_clamped = '0;
        end else if (luma > $signed({1'b0, ONE_Q16})) begin
            luma_clamped = ONE_Q16;
        end else begin
            luma_clamped = luma[16:0];
        end
        y_full = {luma_clamped, 8'd0} - {8'd0, luma_clamped};
        data_next.cb = cb_full[23:0];
        data_next.cr = cr_full[23:0];
        data_next.y  = y_full[23:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/lcc_mult.sv @@
// Second stage: the five products of the inverse conversion.
module lcc_mult import lcc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  lcc_ycc_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output lcc_prod_t out_data
);

    logic              valid_reg;
    lcc_prod_t         data_reg;
    lcc_prod_t         data_next;
    logic signed [24:0] y_s;
    logic signed [24:0] cb_s;
    logic signed [24:0] cr_s;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        y_s  = $signed({1'b0, in_data.y});
        cb_s = $signed({1'b0, in_data.cb});
        cr_s = $signed({1'b0, in_data.cr});
        data_next.y_k  = y_s * K_Y;
        data_next.cr_r = cr_s * K_R_CR;
        data_next.cb_g = cb_s * K_G_CB;
        data_next.cr_g = cr_s * K_G_CR;
        data_next.cb_b = cb_s * K_B_CB;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/lcc_sum_clamp.sv @@
// Third and fourth stages: sum with offsets, then clamp to bytes.
module lcc_sum_clamp import lcc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  lcc_prod_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    logic      sum_valid_reg;
    lcc_sum_t  sum_reg;
    lcc_sum_t  sum_next;
    logic      out_valid_reg;
    logic      out_stage_ready;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;

    function automatic logic [7:0] to_byte(input logic signed [SUM_W-1:0] v);
        logic [7:0] res;
        if (v[SUM_W-1]) begin
            res = 8'd0;
        end else if (v[SUM_W-2:40] != '0) begin
            res = 8'd255;
        end else begin
            res = v[39:32];
        end
        return res;
    endfunction

    assign out_stage_ready = !out_valid_reg || out_ready;
    assign in_ready        = !sum_valid_reg || out_stage_ready;

    always_comb begin
        sum_next.r = in_data.y_k + in_data.cr_r + OFF_R_Q32;
        sum_next.g = in_data.y_k + in_data.cb_g + in_data.cr_g + OFF_G_Q32;
        sum_next.b = in_data.y_k + in_data.cb_b + OFF_B_Q32;
        red_next   = to_byte(sum_reg.r);
        green_next = to_byte(sum_reg.g);
        blue_next  = to_byte(sum_reg.b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                sum_valid_reg <= in_valid;
            end
            if (out_stage_ready) begin
                out_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sum_reg <= sum_next;
        end
        if (sum_valid_reg && out_stage_ready) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

@@ hw/rtl/luma_replace_color_convert.sv @@
// Top level of the luma replacing color converter.
//
// One pixel per beat on each side. The slave side takes 8-bit red, green
// and blue plus an 18-bit signed replacement luma (Q16, clamped to 0..1).
// The block forms BT.601 studio-range Cb and Cr from the pixel, drops the
// pixel's own luma and converts the new luma with Cb and Cr back to RGB,
// each channel clamped to 0..255 and truncated.
// Path: a pixel passes the chroma, product, sum and output registers.
// Throughput: one pixel per clock while m_tready is high, set by the four-stage
// pipeline (chroma and luma, products, sums, clamp and output register).
// Reset: aresetn low clears all valid bits; no pixel is in flight after.
// Stall: a low m_tready holds the output beat; earlier stages keep filling
// their empty slots, and s_tready drops only when all four stages are full.
// s_tready depends combinationally on m_tready.
module luma_replace_color_convert import lcc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16],
                                   // new_luma[41:24], zero[47:42]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red_out[7:0], green_out[15:8], blue_out[23:16]
);

    logic      ycc_valid;
    logic      ycc_ready;
    lcc_ycc_t  ycc_data;
    logic      prod_valid;
    logic      prod_ready;
    lcc_prod_t prod_data;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    lcc_chroma u_chroma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .luma      ($signed(s_tdata[41:24])),
        .out_valid (ycc_valid),
        .out_ready (ycc_ready),
        .out_data  (ycc_data)
    );

    lcc_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ycc_valid),
        .in_ready  (ycc_ready),
        .in_data   (ycc_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    lcc_sum_clamp u_sum_clamp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red       (red_out),
        .green     (green_out),
        .blue      (blue_out)
    );

    assign m_tdata = {blue_out, green_out, red_out};

endmodule

@@ hw/rtl/lcc_checker.sv @@
// Port checker for the luma replacing color converter, bound to the top level.
`include "assert_macros.svh"

module lcc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    assign cnt_next = cnt_reg + 3'(s_tvalid && s_tready) - 3'(m_tvalid && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    `LCC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    `LCC_ASSERT(a_hold_beat, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled beat changed")
    `LCC_ASSERT(a_depth, aclk, aresetn, cnt_reg <= 3'd4, "more than four beats in flight")
    `LCC_ASSERT(a_no_invent, aclk, aresetn, m_tvalid |-> cnt_reg != 3'd0, "output beat without input")
    `LCC_ASSERT(a_stall_cause, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready, "input stalled without output stall")

endmodule

bind luma_replace_color_convert lcc_checker u_lcc_checker (.*);
